>>> rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared codes, field widths and controller/datapath interface types for the
// bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   // Payload and register field widths.
   localparam int IDX_W      = 12;
   localparam int CFG_W      = 13;
   localparam int OP_W       = 2;
   localparam int ST_W       = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Request opcodes.
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

   // Result status codes.
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

   // Register map: the register index is the word address bit above the
   // byte offset.
   localparam logic REG_NUM_BLOCKS = 1'b0;

   localparam logic [CFG_W-1:0] NUM_BLOCKS_RESET = 13'd4096;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;     // write a zero word during the clearing pass
      logic init;      // latch a new item and restart the word walk
      logic scan;      // read the next bitmap word
      logic commit;    // write back the updated word, result ok
      logic fail;      // no free block, result full
      logic load_out;  // move the result into the output register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic bad_req;
      logic hit;
      logic exhausted;
   } dp_sts_type;

endpackage

>>> rtl/core/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for the bitmap block allocator: clearing pass, item accept,
// word walk and result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bba_pkg::dp_cmd_type cmd,
   input  bba_pkg::dp_sts_type sts
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.init = 1'b1;
               state_in = sts.bad_req ? S_DONE : S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.scan = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // Read data for the previous word is valid in every cycle here.
            if (sts.hit) begin
               cmd.commit = 1'b1;
               state_in   = S_DONE;
            end else if (sts.exhausted) begin
               cmd.fail = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap memory, word walk counters, free-bit search, read-modify-write and
// the result registers of the bitmap block allocator.
// ----------------------------------------------------------------------------
module bba_datapath #(
   parameter int MAX_BLOCKS = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bba_pkg::CFG_W-1:0]   num_blocks,
   input  logic [bba_pkg::OP_W-1:0]    req_op,
   input  logic [bba_pkg::IDX_W-1:0]   req_block_index,
   input  bba_pkg::dp_cmd_type         cmd,
   output bba_pkg::dp_sts_type         sts,
   output logic [bba_pkg::IDX_W-1:0]   rsp_result_index,
   output logic [bba_pkg::ST_W-1:0]    rsp_status
);

   localparam int WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int POS_W   = $clog2(WORD_BITS);
   localparam int BASE_W  = $clog2(WORDS * WORD_BITS + 2 * WORD_BITS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int LIM_W   = (CNT_W > bba_pkg::CFG_W) ? CNT_W : bba_pkg::CFG_W;
   localparam int CMP_W   = (BASE_W > LIM_W) ? BASE_W : LIM_W;

   logic [WORD_BITS-1:0] bitmap_mem [WORDS];

   logic [WADDR_W-1:0]          addr_ff, addr_in;
   logic [WADDR_W-1:0]          addr_d_ff, addr_d_in;
   logic [CMP_W-1:0]            base_ff, base_in;
   logic [CMP_W-1:0]            base_d_ff, base_d_in;
   logic [bba_pkg::OP_W-1:0]    op_ff, op_in;
   logic [bba_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [bba_pkg::IDX_W-1:0]   res_idx_ff, res_idx_in;
   logic [bba_pkg::ST_W-1:0]    res_st_ff, res_st_in;
   logic [bba_pkg::IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [bba_pkg::ST_W-1:0]    rsp_st_ff, rsp_st_in;
   logic [WORD_BITS-1:0]        rdata_ff;

   logic [CMP_W-1:0]            num_ext;
   logic [CMP_W-1:0]            limit;
   logic                        bad_req;
   logic                        last_word;
   logic                        is_alloc;
   logic                        word_live;
   logic [CMP_W-1:0]            rem;
   logic [WORD_BITS-1:0]        free_bits;
   logic                        found;
   logic [POS_W-1:0]            free_pos;
   logic [CMP_W-1:0]            idx_ext;
   logic [CMP_W-1:0]            idx_off;
   logic                        idx_hit;
   logic [POS_W-1:0]            sel_pos;
   logic [WORD_BITS-1:0]        bit_mask;
   logic [WORD_BITS-1:0]        wr_word;
   logic [CMP_W-1:0]            alloc_idx;
   logic                        mem_we;
   logic [WADDR_W-1:0]          mem_waddr;
   logic [WORD_BITS-1:0]        mem_wdata;

   // A count above capacity acts as the capacity.
   always_comb begin
      num_ext = CMP_W'(num_blocks);
      limit   = (num_ext > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : num_ext;
   end

   always_comb begin
      if (req_op == bba_pkg::OP_ALLOC) begin
         bad_req = 1'b0;
      end else if (req_op inside {bba_pkg::OP_MARK, bba_pkg::OP_FREE}) begin
         bad_req = (CMP_W'(req_block_index) >= limit);
      end else begin
         bad_req = 1'b1;
      end
   end

   assign last_word = (addr_ff == WADDR_W'(WORDS - 1));
   assign is_alloc  = (op_ff == bba_pkg::OP_ALLOC);

   // Evaluate the word that was read in the previous cycle. Bits at or above
   // the block count count as used, so the search never returns them.
   always_comb begin
      word_live = (base_d_ff < limit);
      rem       = limit - base_d_ff;
      for (int j = 0; j < WORD_BITS; j++) begin
         free_bits[j] = word_live && (CMP_W'(j) < rem) && !rdata_ff[j];
      end
      found    = 1'b0;
      free_pos = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (free_bits[j]) begin
            found    = 1'b1;
            free_pos = POS_W'(j);
         end
      end
      idx_ext   = CMP_W'(idx_ff);
      idx_off   = idx_ext - base_d_ff;
      idx_hit   = (idx_ext >= base_d_ff) && (idx_off < CMP_W'(WORD_BITS));
      sel_pos   = is_alloc ? free_pos : idx_off[POS_W-1:0];
      bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << sel_pos;
      wr_word   = (op_ff == bba_pkg::OP_FREE) ? (rdata_ff & ~bit_mask)
                                              : (rdata_ff | bit_mask);
      alloc_idx = base_d_ff + CMP_W'(free_pos);
   end

   always_comb begin
      sts.clear_done = last_word;
      sts.bad_req    = bad_req;
      sts.hit        = is_alloc ? found : idx_hit;
      sts.exhausted  = is_alloc && !word_live;
   end

   always_comb begin
      addr_in    = addr_ff;
      addr_d_in  = addr_d_ff;
      base_in    = base_ff;
      base_d_in  = base_d_ff;
      op_in      = op_ff;
      idx_in     = idx_ff;
      res_idx_in = res_idx_ff;
      res_st_in  = res_st_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_st_in  = rsp_st_ff;
      if (cmd.clear) begin
         addr_in = addr_ff + WADDR_W'(1);
      end
      if (cmd.init) begin
         addr_in    = '0;
         base_in    = '0;
         op_in      = req_op;
         idx_in     = req_block_index;
         // Only used when the item is refused without a walk.
         res_idx_in = req_block_index;
         res_st_in  = bba_pkg::ST_RANGE;
      end
      if (cmd.scan) begin
         addr_in   = last_word ? addr_ff : (addr_ff + WADDR_W'(1));
         base_in   = base_ff + CMP_W'(WORD_BITS);
         addr_d_in = addr_ff;
         base_d_in = base_ff;
      end
      if (cmd.commit) begin
         res_idx_in = is_alloc ? alloc_idx[bba_pkg::IDX_W-1:0] : idx_ff;
         res_st_in  = bba_pkg::ST_OK;
      end
      if (cmd.fail) begin
         res_idx_in = '0;
         res_st_in  = bba_pkg::ST_FULL;
      end
      if (cmd.load_out) begin
         rsp_idx_in = res_idx_ff;
         rsp_st_in  = res_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else begin
         addr_ff <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_d_ff  <= addr_d_in;
      base_ff    <= base_in;
      base_d_ff  <= base_d_in;
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      res_idx_ff <= res_idx_in;
      res_st_ff  <= res_st_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign mem_we    = cmd.clear | cmd.commit;
   assign mem_waddr = cmd.clear ? addr_ff : addr_d_ff;
   assign mem_wdata = cmd.clear ? '0 : wr_word;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.scan) begin
         rdata_ff <= bitmap_mem[addr_ff];
      end
   end

   assign rsp_result_index = rsp_idx_ff;
   assign rsp_status       = rsp_st_ff;

endmodule

>>> rtl/core/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit free-block bitmap allocator with mark-used and free requests and
// a programmable block count.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  req      in         req_valid / req_stall     req_op, req_block_index
//  rsp      out        rsp_valid / rsp_stall     rsp_result_index, rsp_status
//  csr      in/out     csr_psel/penable/pready   num_blocks at byte address 0
//
// One item is processed at a time; each item gives one result item.
// An allocate reads bitmap words, one per cycle from the single-port bitmap
// memory and at most WORDS + 1, until it finds a free bit or passes the count.
// Mark-used and free walk to their word the same way; a refused item does not.
// After reset a clearing pass writes all WORDS words, one per cycle
// (WORDS = MAX_BLOCKS / WORD_BITS rounded up), while req_stall stays high.
// A finished result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
   parameter int MAX_BLOCKS = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bba_pkg::OP_W-1:0]          req_op,
   input  logic [bba_pkg::IDX_W-1:0]         req_block_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bba_pkg::IDX_W-1:0]         rsp_result_index,
   output logic [bba_pkg::ST_W-1:0]          rsp_status,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bba_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bba_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bba_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   logic [bba_pkg::CFG_W-1:0] num_blocks_ff;
   logic [bba_pkg::CFG_W-1:0] num_blocks_in;
   logic                      reg_sel;
   bba_pkg::dp_cmd_type       cmd;
   bba_pkg::dp_sts_type       sts;

   assign reg_sel    = (csr_paddr[bba_pkg::CSR_ADDR_W-1] == bba_pkg::REG_NUM_BLOCKS);
   assign csr_pready = 1'b1;

   always_comb begin
      num_blocks_in = num_blocks_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         num_blocks_in = csr_pwdata[bba_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_blocks_ff <= bba_pkg::NUM_BLOCKS_RESET;
      end else begin
         num_blocks_ff <= num_blocks_in;
      end
   end

   assign csr_prdata = reg_sel ? bba_pkg::CSR_DATA_W'(num_blocks_ff) : '0;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   bba_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .WORD_BITS  (WORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .num_blocks       (num_blocks_ff),
      .req_op           (req_op),
      .req_block_index  (req_block_index),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_result_index (rsp_result_index),
      .rsp_status       (rsp_status)
   );

endmodule

>>> rtl/core/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks for the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [bba_pkg::IDX_W-1:0]   rsp_result_index,
   input logic [bba_pkg::ST_W-1:0]    rsp_status
);

   // A stalled result item holds its contents.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_index)
                                    && $stable(rsp_status);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("stalled result item changed");

   // Only one item is in flight: the cycle after an accept is stalled.
   property p_one_in_flight;
      @(posedge clock) disable iff (reset)
         req_valid && !req_stall |=> req_stall;
   endproperty
   a_one_in_flight: assert property (p_one_in_flight)
      else $error("item accepted while another was in flight");

   // The clearing pass keeps the input closed and no result out after reset.
   property p_after_reset;
      @(posedge clock)
         $past(reset) |-> req_stall && !rsp_valid;
   endproperty
   a_after_reset: assert property (p_after_reset)
      else $error("block active during clearing pass");

   // A failed allocate reports block zero.
   property p_full_index;
      @(posedge clock) disable iff (reset)
         rsp_valid && (rsp_status == bba_pkg::ST_FULL) |-> rsp_result_index == '0;
   endproperty
   a_full_index: assert property (p_full_index)
      else $error("full status with nonzero index");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_index (rsp_result_index),
   .rsp_status       (rsp_status)
);
